[src/assert_macros.svh]
// assertion macros shared by the checker files
// each macro expects clk and rst_n to be visible where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

[src/krr_pkg.sv]
// types and codes for the keyed region registry
// no dependencies
`default_nettype none

package krr_pkg;

  // operation codes; the unused code acts as a query
  localparam logic [1:0] OP_DECLARE  = 2'd0;
  localparam logic [1:0] OP_WITHDRAW = 2'd1;
  localparam logic [1:0] OP_QUERY    = 2'd2;

  // result status codes
  localparam logic [2:0] ST_DONE        = 3'd0;
  localparam logic [2:0] ST_DUPLICATE   = 3'd1;
  localparam logic [2:0] ST_REJECTED    = 3'd2;
  localparam logic [2:0] ST_NULL        = 3'd3;
  localparam logic [2:0] ST_NOT_PRESENT = 3'd4;

  // input word
  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] region_key;
    logic [63:0] region_size;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [2:0]  status;
    logic        key_found;
    logic [63:0] total_bytes;
    logic [6:0]  entry_count;
    logic [63:0] rejection_total;
  } out_word_t;

  // search token passed from cell to cell
  typedef struct packed {
    logic        vld;
    logic        hit;
    logic [63:0] size;
  } chain_t;

  // table update broadcast to every cell at the end of a scan
  typedef struct packed {
    logic        store;
    logic        shift;
    logic [63:0] key;
    logic [63:0] size;
  } commit_t;

  // controller states
  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

endpackage

`default_nettype wire

[src/keyed_region_registry.sv]
// top level of the keyed region registry: controller, counters and the cell row
// depends on krr_pkg and krr_cell
`default_nettype none

// Usage
// A word is taken on in_word at a rising edge where start is high and busy is
// low. operation selects declare, withdraw or query; region_key names the
// region and region_size is used by a declare only.
// Each word gives exactly one result: out_valid is high for one cycle with
// out_word, which carries the status, whether the key was held before, and
// the byte total, entry count and rejection count after the word.
// Timing: the search token walks the row of ENTRIES cells one cell a cycle;
// the table is updated at the edge where it leaves the last cell, which also
// registers the result. busy is low from the cycle the result shows on, so a
// new word waits until the last one is done. The row length sets this.
// Reset (rst_n low, synchronous) empties the table and clears the byte total
// and the rejection count; slot contents are not cleared, no sweep is needed.
// The receiver cannot stall: out_valid is a one-cycle strobe that must be
// taken when shown.

module keyed_region_registry
  import krr_pkg::*;
#(
  parameter int ENTRIES = 64
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_word_t in_word,
  output logic          out_valid,
  output out_word_t     out_word
);

  localparam int CW = $clog2(ENTRIES + 1);

  state_t      state_r, state_nxt;
  logic        launch_r;
  logic [1:0]  op_r;
  logic [63:0] key_r, size_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [63:0] sum_r, sum_nxt, rej_r, rej_nxt;
  logic        out_valid_r;
  out_word_t   out_word_r, out_word_nxt;
  logic        accept, finish, launch;
  commit_t     commit;

  chain_t      link [ENTRIES+1];
  logic [63:0] cell_key  [ENTRIES];
  logic [63:0] cell_size [ENTRIES];

  assign accept = start && (state_r == S_IDLE);
  assign finish = (state_r == S_SCAN) && link[ENTRIES].vld;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_SCAN;
      S_SCAN:  if (finish) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy   = 1'b1;
    launch = 1'b0;
    case (state_r)
      S_IDLE:  busy = 1'b0;
      S_SCAN:  launch = 1'b0;
      default: busy = 1'b1;
    endcase
    launch = accept;
  end

  // decide the outcome once the token leaves the last cell
  always_comb begin
    count_nxt    = count_r;
    sum_nxt      = sum_r;
    rej_nxt      = rej_r;
    commit       = '{store: 1'b0, shift: 1'b0, key: key_r, size: size_r};
    out_word_nxt = '{status: ST_DONE, key_found: link[ENTRIES].hit,
                     total_bytes: 64'd0, entry_count: 7'd0, rejection_total: 64'd0};
    if (finish) begin
      case (op_r)
        OP_DECLARE: begin
          if (key_r == 64'd0) begin
            out_word_nxt.status    = ST_NULL;
            out_word_nxt.key_found = 1'b0;
          end else if (link[ENTRIES].hit) begin
            out_word_nxt.status = ST_DUPLICATE;
          end else if (count_r == CW'(ENTRIES)) begin
            rej_nxt             = rej_r + 64'd1;
            out_word_nxt.status = ST_REJECTED;
          end else begin
            commit.store = 1'b1;
            count_nxt    = count_r + CW'(1);
            sum_nxt      = sum_r + size_r;
          end
        end
        OP_WITHDRAW: begin
          if (link[ENTRIES].hit) begin
            commit.shift = 1'b1;
            count_nxt    = count_r - CW'(1);
            sum_nxt      = sum_r - link[ENTRIES].size;
          end else begin
            out_word_nxt.status = ST_NOT_PRESENT;
          end
        end
        default: begin
          if (!link[ENTRIES].hit) out_word_nxt.status = ST_NOT_PRESENT;
        end
      endcase
    end
    out_word_nxt.total_bytes     = sum_nxt;
    out_word_nxt.entry_count     = 7'(count_nxt);
    out_word_nxt.rejection_total = rej_nxt;
  end

  // control and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      launch_r    <= 1'b0;
      count_r     <= '0;
      sum_r       <= 64'd0;
      rej_r       <= 64'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      launch_r    <= launch;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      rej_r       <= rej_nxt;
      out_valid_r <= finish;
    end
  end

  // captured word and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_word.operation;
      key_r  <= in_word.region_key;
      size_r <= in_word.region_size;
    end
    if (finish) out_word_r <= out_word_nxt;
  end

  // token enters the first cell in the cycle after acceptance
  assign link[0] = '{vld: launch_r, hit: 1'b0, size: 64'd0};

  // row of cells, each reading its upper neighbor when a gap is closed
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [63:0] nb_key, nb_size;
    if (i == ENTRIES - 1) begin : g_end
      assign nb_key  = cell_key[i];
      assign nb_size = cell_size[i];
    end else begin : g_mid
      assign nb_key  = cell_key[i+1];
      assign nb_size = cell_size[i+1];
    end
    krr_cell #(.ENTRIES(ENTRIES), .IDX(i)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .probe_key (key_r),
      .count     (count_r),
      .chain_in  (link[i]),
      .chain_out (link[i+1]),
      .commit    (commit),
      .nb_key    (nb_key),
      .nb_size   (nb_size),
      .key_out   (cell_key[i]),
      .size_out  (cell_size[i])
    );
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

[src/krr_cell.sv]
// one table slot: holds a key and size, compares the token's key and passes it on
// depends on krr_pkg
`default_nettype none

module krr_cell
  import krr_pkg::*;
#(
  parameter int ENTRIES = 64,
  parameter int IDX     = 0,
  localparam int CW     = $clog2(ENTRIES + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [63:0]   probe_key,
  input  wire logic [CW-1:0] count,
  input  wire chain_t        chain_in,
  output chain_t             chain_out,
  input  wire commit_t       commit,
  input  wire logic [63:0]   nb_key,
  input  wire logic [63:0]   nb_size,
  output logic [63:0]        key_out,
  output logic [63:0]        size_out
);

  logic [63:0] key_r, size_r;
  logic        tok_vld_r, tok_hit_r, mark_r;
  logic [63:0] tok_size_r;
  logic        live, at_tail, match;
  logic        tok_hit_nxt, mark_nxt;
  logic [63:0] tok_size_nxt;

  // slot occupancy and compare
  always_comb begin
    live         = CW'(IDX) < count;
    at_tail      = CW'(IDX) == count;
    match        = chain_in.vld && live && (key_r == probe_key);
    tok_hit_nxt  = chain_in.hit | match;
    tok_size_nxt = match ? size_r : chain_in.size;
    mark_nxt     = chain_in.vld ? (chain_in.hit | match) : mark_r;
  end

  // token and mark registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_vld_r <= 1'b0;
      tok_hit_r <= 1'b0;
      mark_r    <= 1'b0;
    end else begin
      tok_vld_r <= chain_in.vld;
      tok_hit_r <= tok_hit_nxt;
      mark_r    <= mark_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_size_r <= tok_size_nxt;
  end

  // slot contents: append at the tail, or close the gap left by a withdraw
  always_ff @(posedge clk) begin
    if (commit.store && at_tail) begin
      key_r  <= commit.key;
      size_r <= commit.size;
    end else if (commit.shift && mark_r) begin
      key_r  <= nb_key;
      size_r <= nb_size;
    end
  end

  assign chain_out = '{vld: tok_vld_r, hit: tok_hit_r, size: tok_size_r};
  assign key_out   = key_r;
  assign size_out  = size_r;

endmodule

`default_nettype wire

[src/krr_checker.sv]
// port-level checks for the keyed region registry, bound to the top level
// depends on krr_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module krr_checker
  import krr_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire logic      out_valid,
  input wire out_word_t out_word
);

  logic accept;

  assign accept = start && !busy;

  // a result arrives only when the block is free again
  `ASSERT_SAME(a_result_idle, out_valid, !busy)
  // an accepted word makes the block busy with no result in the next cycle
  `ASSERT_NEXT(a_accept_busy, accept, busy && !out_valid)
  // one strobe per word
  `ASSERT_NEXT(a_single_strobe, out_valid, !out_valid)
  // duplicate declare always reports the key as held
  `ASSERT_SAME(a_dup_found, out_valid && (out_word.status == ST_DUPLICATE), out_word.key_found)

endmodule

bind keyed_region_registry krr_checker u_krr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_word  (out_word)
);

`default_nettype wire

[sim/keyed_region_registry_tb.sv]
// self-checking testbench for keyed_region_registry: directed table, a fill past capacity, then phased random words
// depends on krr_pkg and the keyed_region_registry rtl; checked against a local table model
`default_nettype none

module keyed_region_registry_tb;
  import krr_pkg::*;

  localparam int          ENTRIES       = 64;
  localparam int          CLK_HALF      = 10;
  localparam int          POOL_SIZE     = 96;
  localparam int          FILL_WORDS    = 70;
  localparam int          RANDOM_WORDS  = 1560;
  localparam int          PHASE_LEN     = 120;
  localparam int          QUIET_TAIL    = 150;
  localparam int          STALL_LIMIT   = 1000;
  localparam int          MAX_REPORTS   = 10;
  localparam logic [1:0]  OP_SPARE      = 2'd3;
  localparam logic [63:0] ONES          = '1;
  localparam logic [63:0] MSB_KEY       = 64'h8000_0000_0000_0000;

  typedef enum int {
    PH_FILL,
    PH_DRAIN,
    PH_MIX
  } phase_t;

  // one directed stimulus row; result is used only when typed is set
  typedef struct {
    in_word_t  word;
    bit        typed;
    out_word_t result;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_word;
  logic      out_valid;
  out_word_t out_word;

  // local model of the table
  logic [63:0] held_keys  [ENTRIES];
  logic [63:0] held_sizes [ENTRIES];
  int unsigned held_n;
  logic [63:0] byte_total;
  logic [63:0] reject_total;

  out_word_t   predicted_results[$];
  stim_row_t   directed_rows[$];
  logic [63:0] key_pool[POOL_SIZE];

  bit gaps_on;
  int words_sent;
  int results_seen;
  int mismatches;
  int stall_cycles;
  int max_held;
  int status_seen[5];

  keyed_region_registry #(
    .ENTRIES(ENTRIES)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  // clock
  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // table model: one result word per input word
  function automatic out_word_t registry_predict(input in_word_t w);
    out_word_t r;
    int        slot;
    slot        = -1;
    r.status    = ST_DONE;
    r.key_found = 1'b0;
    for (int i = 0; i < int'(held_n); i++) begin
      if (slot < 0 && held_keys[i] == w.region_key) slot = i;
    end
    case (w.operation)
      OP_DECLARE: begin
        if (w.region_key == '0) begin
          r.status = ST_NULL;
        end else if (slot >= 0) begin
          r.status    = ST_DUPLICATE;
          r.key_found = 1'b1;
        end else if (held_n >= ENTRIES) begin
          reject_total = reject_total + 64'd1;
          r.status     = ST_REJECTED;
        end else begin
          held_keys[held_n]  = w.region_key;
          held_sizes[held_n] = w.region_size;
          held_n             = held_n + 1;
          byte_total         = byte_total + w.region_size;
        end
      end
      OP_WITHDRAW: begin
        if (slot >= 0) begin
          // last entry moves into the freed slot
          r.key_found      = 1'b1;
          byte_total       = byte_total - held_sizes[slot];
          held_keys[slot]  = held_keys[held_n - 1];
          held_sizes[slot] = held_sizes[held_n - 1];
          held_n           = held_n - 1;
        end else begin
          r.status = ST_NOT_PRESENT;
        end
      end
      default: begin
        // query, and the spare code that behaves as one
        if (slot >= 0) r.key_found = 1'b1;
        else r.status = ST_NOT_PRESENT;
      end
    endcase
    r.total_bytes     = byte_total;
    r.entry_count     = 7'(held_n);
    r.rejection_total = reject_total;
    return r;
  endfunction

  task automatic add_row(input logic [1:0] op, input logic [63:0] key, input logic [63:0] size,
                         input bit typed = 1'b0, input logic [2:0] st = ST_DONE,
                         input logic found = 1'b0, input logic [63:0] bytes = '0,
                         input logic [6:0] held = '0, input logic [63:0] rejects = '0);
    stim_row_t row;
    row.word   = '{operation: op, region_key: key, region_size: size};
    row.typed  = typed;
    row.result = '{status: st, key_found: found, total_bytes: bytes,
                   entry_count: held, rejection_total: rejects};
    directed_rows.push_back(row);
  endtask

  // random word shaped by the current phase
  function automatic in_word_t random_word(input phase_t phase);
    in_word_t w;
    int       roll;
    roll = $urandom_range(0, 99);
    case (phase)
      PH_FILL:  w.operation = roll < 75 ? OP_DECLARE : (roll < 85 ? OP_WITHDRAW : OP_QUERY);
      PH_DRAIN: w.operation = roll < 15 ? OP_DECLARE : (roll < 80 ? OP_WITHDRAW : OP_QUERY);
      default:  w.operation = roll < 40 ? OP_DECLARE : (roll < 70 ? OP_WITHDRAW : OP_QUERY);
    endcase
    if (w.operation == OP_QUERY && $urandom_range(0, 9) == 0) w.operation = OP_SPARE;
    // key: mostly from the pool or the held set, some null and some fresh
    roll = $urandom_range(0, 99);
    if (roll < 4) w.region_key = '0;
    else if (roll < 12) w.region_key = {$urandom, $urandom};
    else if (w.operation != OP_DECLARE && held_n != 0 && roll < 60)
      w.region_key = held_keys[$urandom_range(0, held_n - 1)];
    else w.region_key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    // size
    roll = $urandom_range(0, 99);
    if (roll < 70) w.region_size = {$urandom, $urandom};
    else if (roll < 80) w.region_size = 64'($urandom_range(0, 255));
    else if (roll < 90) w.region_size = ONES;
    else w.region_size = '0;
    return w;
  endfunction

  // present one word, wait for it to be taken, record what should come back
  task automatic send_word(input in_word_t w, input bit typed, input out_word_t typed_result);
    out_word_t predicted;
    int        gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      start <= 1'b0;
      // count gap cycles only where the block could have taken a word
      repeat (gap) begin
        @(posedge clk);
        while (busy) @(posedge clk);
      end
    end
    @(negedge clk);
    start   <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = registry_predict(w);
    predicted_results.push_back(typed ? typed_result : predicted);
    words_sent++;
  endtask

  task automatic report_field(input string what, input logic [63:0] want, input logic [63:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch on %s: expected 0x%016h, got 0x%016h", what, want, got);
  endtask

  // result checker
  always @(posedge clk) begin : result_check
    out_word_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (out_word.status < 3'd5) status_seen[out_word.status]++;
      if (int'(out_word.entry_count) > max_held) max_held = int'(out_word.entry_count);
      if (predicted_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("result word with nothing outstanding");
      end else begin
        want = predicted_results.pop_front();
        if (out_word.status !== want.status)
          report_field("status", 64'(want.status), 64'(out_word.status));
        if (out_word.key_found !== want.key_found)
          report_field("key_found", 64'(want.key_found), 64'(out_word.key_found));
        if (out_word.total_bytes !== want.total_bytes)
          report_field("total_bytes", want.total_bytes, out_word.total_bytes);
        if (out_word.entry_count !== want.entry_count)
          report_field("entry_count", 64'(want.entry_count), 64'(out_word.entry_count));
        if (out_word.rejection_total !== want.rejection_total)
          report_field("rejection_total", want.rejection_total, out_word.rejection_total);
      end
    end
  end

  // watchdog on cycles with no word moving in either direction
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles = 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles = stall_cycles + 1;
    end
  end

  // stimulus and end of run
  initial begin : stimulus
    phase_t phase;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_word      = '0;
    held_n       = 0;
    byte_total   = '0;
    reject_total = '0;
    gaps_on      = 1'b1;
    words_sent   = 0;
    results_seen = 0;
    mismatches   = 0;
    stall_cycles = 0;
    max_held     = 0;
    phase        = PH_FILL;
    foreach (status_seen[i]) status_seen[i] = 0;
    foreach (key_pool[i]) begin
      key_pool[i] = {$urandom, $urandom};
      if (key_pool[i] == '0) key_pool[i] = 64'd1;
    end

    // directed rows: empty table, null key, extremes, wrap, spare code, slot move
    add_row(OP_QUERY,    64'd1, '0,    1'b1, ST_NOT_PRESENT, 1'b0, '0,    7'd0, '0);
    add_row(OP_WITHDRAW, '0,    '0,    1'b1, ST_NOT_PRESENT, 1'b0, '0,    7'd0, '0);
    add_row(OP_DECLARE,  '0,    ONES,  1'b1, ST_NULL,        1'b0, '0,    7'd0, '0);
    add_row(OP_DECLARE,  ONES,  ONES,  1'b1, ST_DONE,        1'b0, ONES,  7'd1, '0);
    add_row(OP_DECLARE,  ONES,  64'd5, 1'b1, ST_DUPLICATE,   1'b1, ONES,  7'd1, '0);
    add_row(OP_DECLARE,  64'd1, 64'd1, 1'b1, ST_DONE,        1'b0, '0,    7'd2, '0);
    add_row(OP_QUERY,    ONES,  '0,    1'b1, ST_DONE,        1'b1, '0,    7'd2, '0);
    add_row(OP_SPARE,    64'd1, ONES,  1'b1, ST_DONE,        1'b1, '0,    7'd2, '0);
    add_row(OP_SPARE,    64'd2, '0,    1'b1, ST_NOT_PRESENT, 1'b0, '0,    7'd2, '0);
    add_row(OP_QUERY,    '0,    '0,    1'b1, ST_NOT_PRESENT, 1'b0, '0,    7'd2, '0);
    add_row(OP_WITHDRAW, ONES,  '0,    1'b1, ST_DONE,        1'b1, 64'd1, 7'd1, '0);
    add_row(OP_WITHDRAW, ONES,  '0,    1'b1, ST_NOT_PRESENT, 1'b0, 64'd1, 7'd1, '0);
    add_row(OP_DECLARE,  MSB_KEY, '0,  1'b1, ST_DONE,        1'b0, 64'd1, 7'd2, '0);
    add_row(OP_DECLARE,  64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    add_row(OP_DECLARE,  64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    add_row(OP_WITHDRAW, 64'd1, ONES);
    add_row(OP_QUERY,    64'hAAAA_AAAA_AAAA_AAAA, '0);
    add_row(OP_WITHDRAW, MSB_KEY, '0);
    add_row(OP_QUERY,    64'h5555_5555_5555_5555, ONES);
    add_row(OP_WITHDRAW, 64'hAAAA_AAAA_AAAA_AAAA, '0);
    add_row(OP_WITHDRAW, 64'h5555_5555_5555_5555, '0);
    add_row(OP_DECLARE,  64'h0123_4567_89AB_CDEF, 64'h7FFF_FFFF_FFFF_FFFF);

    // reset
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].result);

    // fill the table past capacity so declares get rejected
    for (int i = 0; i < FILL_WORDS; i++)
      send_word('{operation: OP_DECLARE, region_key: key_pool[i],
                  region_size: {$urandom, $urandom}}, 1'b0, '0);

    // phased random traffic, no sender gaps at the tail
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % PHASE_LEN == 0) phase = phase_t'($urandom_range(0, 2));
      if (i == RANDOM_WORDS - QUIET_TAIL) gaps_on = 1'b0;
      send_word(random_word(phase), 1'b0, '0);
    end
    @(negedge clk);
    start <= 1'b0;

    // drain
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (ENTRIES + 4) @(posedge clk);

    $display("%0d words sent, %0d results checked, table peaked at %0d entries",
             words_sent, results_seen, max_held);
    $display("status mix: %0d done, %0d duplicate, %0d rejected, %0d null, %0d absent",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
